### sv/sird_pkg.sv
// Shared constants, types and helpers for the signed integer to radix digit converter.
package sird_pkg;

  // Field and storage widths fixed by the interface.
  localparam int NUM_W = 32;
  localparam int CHAR_W = 8;
  localparam int RADIX_W = 5;
  localparam int ALPHA_CHARS = 16;
  localparam int ALPHA_IDX_W = 4;
  localparam int ALPHA_W = ALPHA_CHARS * CHAR_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;

  // Worst case digit count, reached with radix two.
  localparam int MAX_DIGITS = NUM_W;
  localparam int DEFAULT_MAX_RADIX = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_HI = 2'd2;

  // Reset contents: radix ten with the characters "0123456789".
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [CFG_DATA_W-1:0] ALPHA_LO_RESET = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] ALPHA_HI_RESET = 64'h0000_0000_0000_3938;

  // Sign characters.
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Result of the alphabet check.
  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  // Selects one character byte of the packed alphabet.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [ALPHA_W-1:0] alpha,
                                                   input logic [ALPHA_IDX_W-1:0] idx);
    return alpha[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

### sv/signed_int_to_radix_digits.sv
// Top level of the signed integer to radix digit converter.
// A request is taken when start is high and busy is low; the block then checks
// the alphabet, one character per cycle, and, if it is valid, divides the
// magnitude by the radix on a bit-serial divider, once for each digit.
// Characters then appear one per cycle on out_char with strobe high, a leading
// '-' for negative numbers, and last_char on the final digit; the receiver must
// take each one in that cycle. An invalid alphabet ends the request with no
// output. Configuration must be written only while busy is low; the block
// itself does not enforce it.
module signed_int_to_radix_digits import sird_pkg::*; #(
  parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [NUM_W-1:0] number,
  output logic                   strobe,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   last_char,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIG_W = $clog2(MAX_RADIX);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t             state;
  logic [RADIX_W-1:0] radix_length;
  logic [CFG_DATA_W-1:0] alpha_lo;
  logic [CFG_DATA_W-1:0] alpha_hi;
  logic [ALPHA_W-1:0] alphabet;
  logic [NUM_W-1:0]   value;
  logic               neg;
  logic [CNT_W-1:0]   count;
  logic               chk_go;
  logic               div_go;
  chk_status_t        chk_status;
  logic               div_done;
  logic [NUM_W-1:0]   quotient;
  logic [DIG_W-1:0]   remainder;
  logic               push;
  logic               pop;
  logic [DIG_W-1:0]   stack_top;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length <= RADIX_RESET;
      alpha_lo <= ALPHA_LO_RESET;
      alpha_hi <= ALPHA_HI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:    radix_length <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LO: alpha_lo <= cfg_data;
        REG_ALPHA_HI: alpha_hi <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign alphabet = {alpha_hi, alpha_lo};

  sird_alpha_chk #(
    .MAX_RADIX(MAX_RADIX)
  ) u_alpha_chk (
    .clk(clk),
    .rst(rst),
    .start(chk_go),
    .radix_length(radix_length),
    .alphabet(alphabet),
    .status(chk_status)
  );

  sird_divider #(
    .DIG_W(DIG_W)
  ) u_divider (
    .clk(clk),
    .rst(rst),
    .start(div_go),
    .dividend(value),
    .divisor(radix_length[DIG_W:0]),
    .done(div_done),
    .quotient(quotient),
    .remainder(remainder)
  );

  // Remainders go on the stack as they come; digits leave while emitting.
  assign push = (state == S_DIVIDE) && div_done;
  assign pop = (state == S_EMIT);

  sird_digit_stack #(
    .DIG_W(DIG_W),
    .DEPTH(MAX_DIGITS)
  ) u_digit_stack (
    .clk(clk),
    .push(push),
    .pop(pop),
    .din(remainder),
    .dout(stack_top)
  );

  // Sequencer: check, divide digit by digit, then emit the sign (if negative) and digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      chk_go <= 1'b0;
      div_go <= 1'b0;
      count <= '0;
    end else begin
      strobe <= 1'b0;
      chk_go <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg <= number[NUM_W-1];
            value <= number[NUM_W-1] ? (~number + NUM_W'(1)) : number;
            chk_go <= 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk_status.done) begin
            if (chk_status.ok) begin
              div_go <= 1'b1;
              count <= '0;
              state <= S_DIVIDE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            value <= quotient;
            count <= count + 1'b1;
            if ((quotient != '0) && (count < CNT_W'(MAX_DIGITS - 1))) begin
              div_go <= 1'b1;
            end else begin
              state <= neg ? S_SIGN : S_EMIT;
            end
          end
        end
        S_SIGN: begin
          strobe <= 1'b1;
          out_char <= CH_MINUS;
          last_char <= 1'b0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          out_char <= digit_char(alphabet, ALPHA_IDX_W'(stack_top));
          last_char <= (count == CNT_W'(1));
          count <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### sv/sird_alpha_chk.sv
// Alphabet checker: tests one character per cycle against the sign characters and all later ones in use.
module sird_alpha_chk import sird_pkg::*; #(
  parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RADIX_W-1:0]   radix_length,
  input  logic [ALPHA_W-1:0]   alphabet,
  output chk_status_t          status
);

  localparam int IDX_W = $clog2(MAX_RADIX);

  logic [IDX_W-1:0]  idx;
  logic              running;
  logic              ok;
  logic              done;
  logic [CHAR_W-1:0] cur;
  logic              in_use;
  logic              hit;
  logic              range_ok;

  // The radix must lie between two and the largest supported radix.
  assign range_ok = (radix_length >= RADIX_W'(2)) && (radix_length <= RADIX_W'(MAX_RADIX));

  // Compare the current character with the sign characters and every later one in use.
  always_comb begin
    cur = digit_char(alphabet, ALPHA_IDX_W'(idx));
    in_use = RADIX_W'(idx) < radix_length;
    hit = (cur == CH_PLUS) || (cur == CH_MINUS);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((j > int'(idx)) && (RADIX_W'(j) < radix_length) &&
          (digit_char(alphabet, ALPHA_IDX_W'(j)) == cur)) begin
        hit = 1'b1;
      end
    end
    hit = hit && in_use;
  end

  // Sweep over the character positions, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      ok <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        idx <= '0;
        ok <= range_ok;
      end else if (running) begin
        if (hit) begin
          ok <= 1'b0;
        end
        if (idx == IDX_W'(MAX_RADIX - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.ok = ok;

endmodule

### sv/sird_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle over a narrow remainder.
module sird_divider import sird_pkg::*; #(
  parameter int DIG_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DIG_W:0]   divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DIG_W-1:0] remainder
);

  localparam int STEP_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  q;
  logic [DIG_W-1:0]  r;
  logic [STEP_W-1:0] step;
  logic              running;
  logic [DIG_W:0]    trial;
  logic              ge;
  logic [DIG_W:0]    diff;

  // One step: bring down the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {r, q[NUM_W-1]};
    ge = trial >= divisor;
    diff = trial - divisor;
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step <= '0;
        q <= dividend;
        r <= '0;
      end else if (running) begin
        q <= {q[NUM_W-2:0], ge};
        r <= ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
        if (step == STEP_W'(NUM_W - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign quotient = q;
  assign remainder = r;

endmodule

### sv/sird_digit_stack.sv
// Digit stack: a shift register that takes digits least significant first and
// gives them back most significant first.
module sird_digit_stack #(
  parameter int DIG_W = 4,
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             push,
  input  logic             pop,
  input  logic [DIG_W-1:0] din,
  output logic [DIG_W-1:0] dout
);

  logic [DIG_W-1:0] slots [DEPTH];

  // Push moves every entry one place down, pop one place up.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        slots[k] <= slots[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        slots[k] <= slots[k+1];
      end
    end
  end

  assign dout = slots[0];

endmodule

### sv/sird_checker.sv
// Port-level checks on the converter, bound to the top level.
module sird_checker import sird_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    strobe,
  input logic [CHAR_W-1:0]       out_char,
  input logic                    last_char
);

  // A taken request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // Nothing follows the final character of a number straight away.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |=> !strobe)
    else $error("character directly after the final one");

  // A character that is not the final one comes while the block is still busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |-> busy)
    else $error("non-final character while idle");

  // The minus sign can only lead, so it never ends a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (out_char == CH_MINUS) |-> !last_char)
    else $error("minus sign flagged as final character");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (.*);
